/* rtl/core/per_sender_flood_policer_assert.svh */
// assertion macros used by the policer top level
`ifndef PER_SENDER_FLOOD_POLICER_ASSERT_SVH
`define PER_SENDER_FLOOD_POLICER_ASSERT_SVH

// property that must hold in the cycle after a trigger
`define PFP_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("assertion failed");

// property that must hold in the same cycle as a trigger
`define PFP_ASSERT_NOW(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error("assertion failed");

`endif

/* rtl/core/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg
// types, constants and helpers of the per-sender flood policer
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int unsigned Senders     = 64;
  localparam int unsigned SidW        = $clog2(Senders);
  localparam int unsigned LogFracBits = 16;
  localparam int unsigned MantBits    = 30;
  // count sum width: senders * 65535
  localparam int unsigned TotW        = 16 + SidW;
  // log value width: integer part up to TotW-1 plus fraction
  localparam int unsigned LogW        = $clog2(TotW) + LogFracBits;
  localparam int unsigned ProdW       = TotW + LogW;

  typedef enum logic [1:0] {
    VerdictAccept    = 2'd0,
    VerdictBlacklist = 2'd1,
    VerdictRandom    = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    RegCountLimit  = 3'd0,
    RegRateLimit   = 3'd1,
    RegRateWindow  = 3'd2,
    RegEntWindow   = 3'd3,
    RegBlacklistMs = 3'd4,
    RegEntThresh   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StRead, StCheck, StCount, StRate, StEntScan, StEntLog,
    StEntDiv, StEntHit, StInc, StClear, StOut
  } state_e;

  typedef struct packed {
    logic [SidW-1:0] sender_id;
    logic [31:0]     now_ms;
    logic [15:0]     random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       count_alarm;
    logic       rate_alarm;
    logic       entropy_alarm;
    logic [6:0] trust_level;
    logic [1:0] drop_level;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  count_limit;
    logic [7:0]  rate_limit;
    logic [15:0] rate_window_ms;
    logic [15:0] entropy_window_ms;
    logic [19:0] blacklist_ms;
    logic [11:0] entropy_threshold;
  } cfg_t;

  // log unit handshake
  typedef struct packed {
    logic            start;
    logic [TotW-1:0] x;
  } log_req_t;

  typedef struct packed {
    logic            done;
    logic [LogW-1:0] y;
  } log_rsp_t;

endpackage

/* rtl/core/per_sender_flood_policer.sv */
// Per-sender flood policer.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one packet: sender
// slot, arrival time in ms and a random word. Output channel (out_valid_o/
// out_ready_i/out_data_o) returns one verdict per packet, in order.
// An APB port writes and reads the six threshold and window registers.
// A dropped packet passes the Read, Check and Out states; a kept one passes
// Read, Check, Count, Rate, EntScan, Inc and Out. One that closes the entropy
// window also walks, between EntScan and Inc, all 64 slots and then the total
// through the log unit, runs one divide and clears the counts slot by slot.
// One packet is in work at a time; the next is taken in the idle cycle after
// the result has moved to the output register.
// Reset: per-sender tables come up with trust 100, level 0, no blacklist and
// zero counts (per-slot valid bits); registers take their reset values.
// When the receiver stalls the result waits in the output register; one more
// packet is taken and worked on, its result is held back until the output
// register is free, and the input stalls meanwhile.
// ----------------------------------------------------------------------------
// per_sender_flood_policer
// top level: sequencer, per-sender tables and configuration registers
// ----------------------------------------------------------------------------
`include "per_sender_flood_policer_assert.svh"

module per_sender_flood_policer import pfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration ----------------
  cfg_t cfg_q;
  logic [2:0] ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_limit       <= 8'd50;
      cfg_q.rate_limit        <= 8'd20;
      cfg_q.rate_window_ms    <= 16'd1000;
      cfg_q.entropy_window_ms <= 16'd2000;
      cfg_q.blacklist_ms      <= 20'd20000;
      cfg_q.entropy_threshold <= 12'd896;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegCountLimit:  cfg_q.count_limit       <= pwdata[7:0];
        RegRateLimit:   cfg_q.rate_limit        <= pwdata[7:0];
        RegRateWindow:  cfg_q.rate_window_ms    <= pwdata[15:0];
        RegEntWindow:   cfg_q.entropy_window_ms <= pwdata[15:0];
        RegBlacklistMs: cfg_q.blacklist_ms      <= pwdata[19:0];
        RegEntThresh:   cfg_q.entropy_threshold <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegCountLimit:  prdata = {24'd0, cfg_q.count_limit};
      RegRateLimit:   prdata = {24'd0, cfg_q.rate_limit};
      RegRateWindow:  prdata = {16'd0, cfg_q.rate_window_ms};
      RegEntWindow:   prdata = {16'd0, cfg_q.entropy_window_ms};
      RegBlacklistMs: prdata = {12'd0, cfg_q.blacklist_ms};
      RegEntThresh:   prdata = {20'd0, cfg_q.entropy_threshold};
      default:        prdata = '0;
    endcase
  end

  // ---------------- per-sender storage ----------------
  logic [6:0]  trust_mem [Senders];
  logic [1:0]  drop_mem  [Senders];
  logic [31:0] bl_mem    [Senders];
  logic [7:0]  flood_mem [Senders];
  logic [7:0]  rcnt_mem  [Senders];
  logic [31:0] rstart_mem[Senders];
  logic [15:0] win_mem   [Senders];
  logic [Senders-1:0] tvalid_q, rseen_q, wvalid_q;

  state_e state_q, state_d;
  in_item_t item_q;
  logic [SidW-1:0] sid;
  assign sid = item_q.sender_id;

  // working copies of the sender entry
  logic [6:0]  trust_q, trust_d;
  logic [1:0]  drop_q, drop_d;
  logic [31:0] bl_q, bl_d;
  logic [7:0]  flood_q, flood_d;
  logic [7:0]  rcnt_q, rcnt_d;
  logic [31:0] rstart_q, rstart_d;
  logic [15:0] wcnt_q, wcnt_d;
  logic        rs_seen_q, rs_seen_d;
  logic        c_al_q, c_al_d, r_al_q, r_al_d, e_al_q, e_al_d;
  logic [1:0]  verdict_q, verdict_d;
  logic [31:0] wstart_q, wstart_d;

  // entropy walk
  logic [SidW-1:0]  idx_q, idx_d;
  logic [ProdW-1:0] sum_q, sum_d;
  logic [TotW-1:0]  tot_q, tot_d;
  logic             tot_phase_q, tot_phase_d;
  logic [15:0]      scan_c_q;
  logic             hit_q, hit_d;

  logic      wr_entry, clr_win;
  out_item_t res_d;
  logic      out_valid_q, out_load;
  out_item_t out_q;

  // shared log and divide units
  log_req_t log_req;
  log_rsp_t log_rsp;
  logic     div_start, div_done;
  logic [ProdW-1:0] div_quo;

  pfp_log2 u_log (.clk_i, .rst_ni, .req_i(log_req), .rsp_o(log_rsp));
  pfp_div  u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(sum_q),
                  .den_i(tot_q), .done_o(div_done), .quo_o(div_quo));

  // trust step applied to the working copy
  function automatic logic [6:0] clamp_trust(input logic [6:0] t, input logic signed [7:0] d);
    logic signed [8:0] v;
    v = $signed({2'b00, t}) + 9'(d);
    if (v < 0) return 7'd0;
    if (v > 9'sd100) return 7'd100;
    return v[6:0];
  endfunction

  logic [6:0]  tstep;
  logic signed [7:0] tdelta;
  logic [31:0] rdiff, wdiff;
  logic [8:0]  rnext;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] thr_ext;

  assign tstep   = clamp_trust(trust_q, tdelta);
  assign rdiff   = item_q.now_ms - rstart_q;
  assign wdiff   = item_q.now_ms - wstart_q;
  assign prod    = ProdW'(tot_phase_q ? tot_q : TotW'(scan_c_q)) * ProdW'(log_rsp.y);
  assign thr_ext = ProdW'({cfg_q.entropy_threshold, {(LogFracBits-8){1'b0}}});

  // walk count read at the next slot index, so it is ready in StEntLog;
  // the count written in the same cycle is taken from the working copy
  always_ff @(posedge clk_i) begin
    if (wr_entry && idx_d == sid) scan_c_q <= wcnt_q;
    else scan_c_q <= wvalid_q[idx_d] ? win_mem[idx_d] : 16'd0;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    trust_d = trust_q; drop_d = drop_q; bl_d = bl_q; flood_d = flood_q;
    rcnt_d = rcnt_q; rstart_d = rstart_q; wcnt_d = wcnt_q; rs_seen_d = rs_seen_q;
    c_al_d = c_al_q; r_al_d = r_al_q; e_al_d = e_al_q; verdict_d = verdict_q;
    wstart_d = wstart_q; idx_d = idx_q; sum_d = sum_q; tot_d = tot_q;
    tot_phase_d = tot_phase_q; hit_d = hit_q;
    tdelta = 8'sd0; rnext = '0;
    wr_entry = 1'b0; clr_win = 1'b0; out_load = 1'b0;
    log_req = '0; div_start = 1'b0;
    res_d = '0;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StRead;
      StRead: begin
        // entry was read at the transfer; unwritten slots take reset values
        trust_d  = tvalid_q[sid] ? trust_q : 7'd100;
        drop_d   = tvalid_q[sid] ? drop_q  : 2'd0;
        bl_d     = tvalid_q[sid] ? bl_q    : 32'd0;
        flood_d  = tvalid_q[sid] ? flood_q : 8'd0;
        rcnt_d   = tvalid_q[sid] ? rcnt_q  : 8'd0;
        rs_seen_d = rseen_q[sid];
        wcnt_d   = wvalid_q[sid] ? wcnt_q : 16'd0;
        c_al_d = 1'b0; r_al_d = 1'b0; e_al_d = 1'b0;
        state_d = StCheck;
      end
      StCheck: begin
        if (item_q.now_ms < bl_q) begin
          verdict_d = VerdictBlacklist;
          state_d   = StOut;
        end else if (drop_q == 2'd2 || (drop_q == 2'd1 && !item_q.random_value[15])) begin
          verdict_d = VerdictRandom;
          state_d   = StOut;
        end else begin
          verdict_d = VerdictAccept;
          state_d   = StCount;
        end
      end
      StCount: begin
        tdelta = -8'sd20;
        if ({1'b0, flood_q} + 9'd1 > {1'b0, cfg_q.count_limit}) begin
          trust_d = tstep; flood_d = '0; c_al_d = 1'b1;
          drop_d = (tstep >= 7'd70) ? 2'd0 : (tstep >= 7'd40) ? 2'd1 : 2'd2;
          if (tstep < 7'd40) bl_d = item_q.now_ms + 32'(cfg_q.blacklist_ms);
        end else flood_d = flood_q + 8'd1;
        state_d = StRate;
      end
      StRate: begin
        tdelta = -8'sd30;
        if (!rs_seen_q) begin
          rs_seen_d = 1'b1; rstart_d = item_q.now_ms; rcnt_d = 8'd1;
        end else begin
          if (rdiff <= 32'(cfg_q.rate_window_ms)) rnext = {1'b0, rcnt_q} + 9'd1;
          else begin
            rnext = 9'd1; rstart_d = item_q.now_ms;
          end
          if (rnext > {1'b0, cfg_q.rate_limit}) begin
            trust_d = tstep; rcnt_d = '0; r_al_d = 1'b1;
            drop_d = (tstep >= 7'd70) ? 2'd0 : (tstep >= 7'd40) ? 2'd1 : 2'd2;
            if (tstep < 7'd40) bl_d = item_q.now_ms + 32'(cfg_q.blacklist_ms);
          end else rcnt_d = rnext[7:0];
        end
        if (wstart_q == 32'd0) wstart_d = item_q.now_ms;
        if (wcnt_q != 16'hFFFF) wcnt_d = wcnt_q + 16'd1;
        state_d = StEntScan;
      end
      StEntScan: begin
        // commit the entry so the walk sees the new count
        wr_entry = 1'b1;
        if (wdiff >= 32'(cfg_q.entropy_window_ms)) begin
          idx_d = '0; sum_d = '0; tot_d = '0; tot_phase_d = 1'b0; hit_d = 1'b0;
          state_d = StEntLog;
        end else state_d = StInc;
      end
      StEntLog: begin
        // one slot a pass: read count, take log, accumulate; last the log of the total
        state_d = StEntDiv;
        log_req.start = 1'b1;
        log_req.x = tot_phase_q ? tot_q : TotW'(scan_c_q);
      end
      StEntDiv: begin
        if (log_rsp.done) begin
          if (!tot_phase_q) begin
            sum_d = sum_q + prod;
            tot_d = tot_q + TotW'(scan_c_q);
            idx_d = idx_q + SidW'(1);
            if (idx_q == SidW'(Senders - 1)) tot_phase_d = 1'b1;
            state_d = StEntLog;
          end else begin
            sum_d = prod - sum_q;
            state_d = StEntHit;
          end
        end
      end
      StEntHit: begin
        if (tot_q == '0) begin
          hit_d = 1'b0;
          idx_d = '0;
          state_d = StClear;
        end else begin
          if (!hit_q) begin
            div_start = 1'b1;
            hit_d = 1'b1;
          end else if (div_done) begin
            hit_d = (div_quo > thr_ext);
            idx_d = '0;
            state_d = StClear;
          end
        end
      end
      StClear: begin
        clr_win = 1'b1;
        wcnt_d = '0;
        idx_d = idx_q + SidW'(1);
        if (idx_q == SidW'(Senders - 1)) begin
          wstart_d = item_q.now_ms;
          if (hit_q) begin
            tdelta = -8'sd40;
            trust_d = tstep; e_al_d = 1'b1;
            drop_d = (tstep >= 7'd70) ? 2'd0 : (tstep >= 7'd40) ? 2'd1 : 2'd2;
            if (tstep < 7'd40) bl_d = item_q.now_ms + 32'(cfg_q.blacklist_ms);
          end
          state_d = StInc;
        end
      end
      StInc: begin
        tdelta = 8'sd1;
        trust_d = tstep;
        drop_d = (tstep >= 7'd70) ? 2'd0 : (tstep >= 7'd40) ? 2'd1 : 2'd2;
        if (tstep < 7'd40) bl_d = item_q.now_ms + 32'(cfg_q.blacklist_ms);
        state_d = StOut;
      end
      StOut: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          wr_entry = 1'b1;
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    res_d.verdict       = verdict_q;
    res_d.count_alarm   = c_al_q;
    res_d.rate_alarm    = r_al_q;
    res_d.entropy_alarm = e_al_q;
    res_d.trust_level   = trust_q;
    res_d.drop_level    = drop_q;
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wstart_q    <= '0;
      tvalid_q    <= '0;
      rseen_q     <= '0;
      wvalid_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q  <= state_d;
      wstart_q <= wstart_d;
      idx_q    <= idx_d;
      if (wr_entry) begin
        tvalid_q[sid] <= 1'b1;
        rseen_q[sid]  <= rs_seen_q;
        wvalid_q[sid] <= 1'b1;
      end
      if (clr_win) wvalid_q[idx_q] <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // working registers, entry read at the input transfer and table writes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q    <= in_data_i;
      trust_q   <= trust_mem[in_data_i.sender_id];
      drop_q    <= drop_mem[in_data_i.sender_id];
      bl_q      <= bl_mem[in_data_i.sender_id];
      flood_q   <= flood_mem[in_data_i.sender_id];
      rcnt_q    <= rcnt_mem[in_data_i.sender_id];
      rstart_q  <= rstart_mem[in_data_i.sender_id];
      wcnt_q    <= win_mem[in_data_i.sender_id];
    end else begin
      trust_q <= trust_d; drop_q <= drop_d; bl_q <= bl_d; flood_q <= flood_d;
      rcnt_q <= rcnt_d; rstart_q <= rstart_d; wcnt_q <= wcnt_d;
    end
    rs_seen_q <= rs_seen_d;
    c_al_q <= c_al_d; r_al_q <= r_al_d; e_al_q <= e_al_d; verdict_q <= verdict_d;
    sum_q <= sum_d; tot_q <= tot_d; tot_phase_q <= tot_phase_d; hit_q <= hit_d;
    if (wr_entry) begin
      trust_mem[sid]  <= trust_q;
      drop_mem[sid]   <= drop_q;
      bl_mem[sid]     <= bl_q;
      flood_mem[sid]  <= flood_q;
      rcnt_mem[sid]   <= rcnt_q;
      rstart_mem[sid] <= rstart_q;
      win_mem[sid]    <= wcnt_q;
    end
    if (out_load) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  `PFP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `PFP_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_q || out_ready_i)
  `PFP_ASSERT_NOW(a_trust_range, out_valid_o, out_data_o.trust_level <= 7'd100)
  `PFP_ASSERT_NOW(a_drop_code, out_valid_o, out_data_o.drop_level != 2'd3)

endmodule

/* rtl/core/pfp_log2.sv */
// ----------------------------------------------------------------------------
// pfp_log2
// iterative fixed-point log2, one fraction bit per squaring step
// ----------------------------------------------------------------------------
module pfp_log2 import pfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  log_req_t req_i,
  output log_rsp_t rsp_o
);

  localparam int unsigned NW = $clog2(TotW);
  localparam int unsigned CW = $clog2(LogFracBits + 1);

  logic              busy_q, busy_d;
  logic [MantBits:0] y_q, y_d;
  logic [LogFracBits-1:0] frac_q, frac_d;
  logic [NW-1:0]     n_q, n_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [2*MantBits+1:0] sq;
  logic [MantBits+1:0]   ysq;
  logic [NW-1:0]     msb;
  logic [MantBits:0] ynorm;

  // msb position of the argument
  always_comb begin
    msb = '0;
    for (int i = 1; i < TotW; i++) begin
      if (req_i.x[i]) msb = NW'(i);
    end
  end

  assign ynorm = (MantBits+1)'(({{(MantBits+1){1'b0}}, req_i.x} << MantBits) >> msb);
  assign sq    = y_q * y_q;
  assign ysq   = (MantBits+2)'(sq >> MantBits);

  // one squaring step a cycle
  always_comb begin
    busy_d = busy_q;
    y_d    = y_q;
    frac_d = frac_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = (req_i.x > TotW'(1));
      done_d = !(req_i.x > TotW'(1));
      y_d    = ynorm;
      n_d    = (req_i.x > TotW'(1)) ? msb : '0;
      frac_d = '0;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (ysq[MantBits+1]) begin
        y_d    = ysq[MantBits+1:1];
        frac_d = {frac_q[LogFracBits-2:0], 1'b1};
      end else begin
        y_d    = ysq[MantBits:0];
        frac_d = {frac_q[LogFracBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(LogFracBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    frac_q <= frac_d;
    n_q    <= n_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = {n_q, frac_q};

endmodule

/* rtl/core/pfp_div.sv */
// ----------------------------------------------------------------------------
// pfp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfp_div import pfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] num_i,
  input  logic [TotW-1:0]  den_i,
  output logic             done_o,
  output logic [ProdW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(ProdW + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [ProdW-1:0] q_q, q_d;
  logic [TotW:0]    r_q, r_d;
  logic [TotW-1:0]  den_q, den_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TotW:0]    trial;

  assign trial = {r_q[TotW-1:0], q_q[ProdW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    q_d    = q_q;
    r_d    = r_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      q_d    = num_i;
      r_d    = '0;
      den_d  = den_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q};
        q_d = {q_q[ProdW-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(ProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule
